[design/ssq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants for the flash erase/program sequencer
// Holds item structs, operation and transfer codes, and flash opcodes.
// ----------------------------------------------------------------------------
package ssq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ERASE   = 2'd1,
    OP_PROGRAM = 2'd2,
    OP_DONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] flash_address;
    logic [7:0]  buffer_index;
    logic [7:0]  buffer_byte;
    logic [7:0]  rx_byte;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        timed_out;
  } xfer_t;

  localparam logic [7:0]  OPC_WREN   = 8'h06;
  localparam logic [7:0]  OPC_RDSR   = 8'h05;
  localparam logic [7:0]  OPC_SE     = 8'h20;
  localparam logic [7:0]  OPC_PP     = 8'h02;
  localparam logic [7:0]  DUMMY_BYTE = 8'hFF;

  localparam logic [23:0] POLL_LIMIT_RESET = 24'd2000000;

  localparam int BUF_DEPTH           = 256;
  localparam int BUF_AW              = 8;
  localparam int PAGE_BYTES_DEFAULT  = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

endpackage
`default_nettype wire

[design/spi_flash_erase_program_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_flash_erase_program_sequencer: byte-level SPI NOR erase/program sequencer
// Turns host commands and shifter completions into a stream of byte transfers.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd): one item per transaction. Load page
//   bytes while idle, then issue an erase or program; after that, feed one
//   transfer-done item per byte the external shifter finishes.
//   xfer channel (xfer_valid/xfer_stall/xfer): zero or one transfer record per
//   item: send a byte, open a new frame, or finish the command with timed_out.
//   cfg channel (cfg_valid/cfg_ready/cfg_poll_limit): poll budget, always ready;
//   write it only while no command is running.
// Timing: one item per cycle while the queue has room; the sequencer finishes
//   each item's phase update in the cycle it is taken. A record enters the
//   queue at the accepting edge and shows on xfer from the output register.
// Stall: a stalled xfer holds its record; the queue keeps absorbing items and
//   cmd_stall rises only once the queue is full.
// Reset: sequencer idles, queue empties, poll budget returns to 2000000. The
//   page buffer is not cleared; program only entries already loaded.
// ----------------------------------------------------------------------------
module spi_flash_erase_program_sequencer
  import ssq_pkg::*;
#(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  output logic             xfer_valid,
  input  wire logic        xfer_stall,
  output xfer_t            xfer,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_poll_limit
);

  logic  accept;
  logic  push;
  xfer_t push_data;
  logic  q_pop;
  xfer_t q_data;
  logic  q_not_empty;
  logic  q_full;

  // Hold intake only while the queue has no free slot
  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  ssq_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd),
    .cfg_write      (cfg_valid),
    .cfg_poll_limit (cfg_poll_limit),
    .push           (push),
    .push_data      (push_data)
  );

  ssq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ssq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .xfer_valid  (xfer_valid),
    .xfer_stall  (xfer_stall),
    .xfer        (xfer)
  );

endmodule
`default_nettype wire

[design/ssq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_front: item intake and command sequencer
// Accepts items, stores page bytes, tracks the command phase and produces
// at most one transfer record per item for the queue.
// ----------------------------------------------------------------------------
module ssq_front
  import ssq_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire cmd_t        cmd,
  input  wire logic        cfg_write,
  input  wire logic [23:0] cfg_poll_limit,
  output logic             push,
  output xfer_t            push_data
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WREN,
    PH_CMD,
    PH_A2,
    PH_A1,
    PH_A0,
    PH_DATA,
    PH_RDSR,
    PH_POLL
  } phase_t;

  localparam logic [8:0] PAGE_END = 9'(PAGE_BYTES);

  phase_t      phase, phase_next;
  logic        is_program, is_program_next;
  logic [23:0] target_address, target_address_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [23:0] polls_left, polls_left_next;
  logic [23:0] poll_limit;

  logic [7:0]  page_buffer [BUF_DEPTH];
  logic [7:0]  buf_rd_data;

  logic        emit;
  xfer_t       res;

  always_comb begin
    phase_next          = phase;
    is_program_next     = is_program;
    target_address_next = target_address;
    byte_count_next     = byte_count;
    polls_left_next     = polls_left;
    emit                = 1'b0;
    res                 = '{kind: KIND_SEND, tx_byte: 8'h00, timed_out: 1'b0};

    if (accept) begin
      if (phase == PH_IDLE) begin
        if (cmd.op == OP_ERASE || cmd.op == OP_PROGRAM) begin
          is_program_next     = (cmd.op == OP_PROGRAM);
          target_address_next = cmd.flash_address;
          byte_count_next     = '0;
          polls_left_next     = poll_limit;
          phase_next          = PH_WREN;
          emit                = 1'b1;
          res.kind            = KIND_FRAME;
          res.tx_byte         = OPC_WREN;
        end
      end else if (cmd.op == OP_DONE) begin
        emit = 1'b1;
        case (phase)
          PH_WREN: begin
            phase_next  = PH_CMD;
            res.kind    = KIND_FRAME;
            res.tx_byte = is_program ? OPC_PP : OPC_SE;
          end
          PH_CMD: begin
            phase_next  = PH_A2;
            res.tx_byte = target_address[23:16];
          end
          PH_A2: begin
            phase_next  = PH_A1;
            res.tx_byte = target_address[15:8];
          end
          PH_A1: begin
            phase_next  = PH_A0;
            res.tx_byte = target_address[7:0];
          end
          PH_A0, PH_DATA: begin
            if (is_program && byte_count < PAGE_END) begin
              byte_count_next = byte_count + 9'd1;
              phase_next      = PH_DATA;
              res.tx_byte     = buf_rd_data;
            end else begin
              phase_next  = PH_RDSR;
              res.kind    = KIND_FRAME;
              res.tx_byte = OPC_RDSR;
            end
          end
          PH_RDSR: begin
            phase_next  = PH_POLL;
            res.tx_byte = DUMMY_BYTE;
          end
          PH_POLL: begin
            if (cmd.rx_byte[0] && polls_left != '0) begin
              polls_left_next = polls_left - 24'd1;
              res.tx_byte     = DUMMY_BYTE;
            end else begin
              phase_next    = PH_IDLE;
              res.kind      = KIND_END;
              res.timed_out = cmd.rx_byte[0];
            end
          end
          default: begin
            phase_next = PH_IDLE;
            emit       = 1'b0;
          end
        endcase
      end
    end
  end

  assign push      = emit;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_program     <= 1'b0;
      target_address <= '0;
      byte_count     <= '0;
      polls_left     <= '0;
      poll_limit     <= POLL_LIMIT_RESET;
    end else begin
      phase          <= phase_next;
      is_program     <= is_program_next;
      target_address <= target_address_next;
      byte_count     <= byte_count_next;
      polls_left     <= polls_left_next;
      if (cfg_write) begin
        poll_limit <= cfg_poll_limit;
      end
    end
  end

  // Page buffer: loads only land while idle, reads run ahead of the data phase
  always_ff @(posedge clk) begin
    if (accept && phase == PH_IDLE && cmd.op == OP_LOAD) begin
      page_buffer[cmd.buffer_index] <= cmd.buffer_byte;
    end
    buf_rd_data <= page_buffer[byte_count_next[BUF_AW-1:0]];
  end

`ifndef NO_ASSERTIONS
  a_start_wren: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && (cmd.op == OP_ERASE || cmd.op == OP_PROGRAM))
      |=> (phase == PH_WREN))
    else $error("command start did not enter write enable phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= PAGE_END)
    else $error("page byte count ran past page size");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.kind == KIND_END) |=> (phase == PH_IDLE))
    else $error("done record without return to idle");
`endif

endmodule
`default_nettype wire

[design/ssq_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_fifo: short transfer record queue
// Decouples the sequencer from the output stage; full throttles intake.
// ----------------------------------------------------------------------------
module ssq_fifo
  import ssq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire xfer_t push_data,
  input  wire logic  pop,
  output xfer_t      pop_data,
  output logic       not_empty,
  output logic       full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  xfer_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == DEPTH_C);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("record pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("record popped from empty queue");
`endif

endmodule
`default_nettype wire

[design/ssq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_back: transfer output stage
// Pops queued records into the output register and hands them to the shifter.
// ----------------------------------------------------------------------------
module ssq_back
  import ssq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_not_empty,
  input  wire xfer_t q_data,
  output logic       q_pop,
  output logic       xfer_valid,
  input  wire logic  xfer_stall,
  output xfer_t      xfer
);

  // Refill whenever the register is empty or being taken this cycle
  assign q_pop = q_not_empty && (!xfer_valid || !xfer_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_valid <= 1'b0;
    end else if (q_pop) begin
      xfer_valid <= 1'b1;
    end else if (!xfer_stall) begin
      xfer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      xfer <= q_data;
    end
  end

endmodule
`default_nettype wire

[tb/spi_flash_erase_program_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_flash_erase_program_sequencer_test: self-checking bench for the sequencer
// Drives erase/program commands, page loads and shifter completions with
// random gaps on both channels. A shadow copy of the sequencer forecasts every
// byte transfer, and each transfer the block hands out is compared with it.
// ----------------------------------------------------------------------------
module spi_flash_erase_program_sequencer_test;
  import ssq_pkg::*;

  localparam int PAGE_BYTES    = PAGE_BYTES_DEFAULT;
  localparam int TARGET_ITEMS  = 1300;
  // Records pass the queue and output register; leave a generous margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 150;
  localparam int STALL_LIMIT   = 3000;

  // Shadow sequencer states: each names the byte whose transfer is pending.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    AWAIT_WREN,
    AWAIT_CMD,
    AWAIT_ADDR_HI,
    AWAIT_ADDR_MID,
    AWAIT_ADDR_LO,
    AWAIT_DATA,
    AWAIT_RDSR,
    AWAIT_STATUS
  } seq_state_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        xfer_valid;
  logic        xfer_stall;
  xfer_t       xfer;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_poll_limit;

  // Shadow state of the sequencer.
  seq_state_t  seq_state       = SEQ_IDLE;
  bit          do_program      = 1'b0;
  logic [23:0] cmd_address     = '0;
  logic [8:0]  bytes_sent      = '0;
  logic [23:0] polls_remaining = '0;
  logic [23:0] poll_budget     = POLL_LIMIT_RESET;
  logic [7:0]  page_copy [BUF_DEPTH];

  xfer_t       due_transfers [$];
  int          effective_items = 0;
  int          mismatch_count  = 0;
  int          hold_request    = 0;
  bit          sender_quiet    = 1'b0;
  bit          receiver_quiet  = 1'b0;

  spi_flash_erase_program_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .xfer_valid    (xfer_valid),
    .xfer_stall    (xfer_stall),
    .xfer          (xfer),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_poll_limit(cfg_poll_limit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Forecast
  // --------------------------------------------------------------------------
  function automatic xfer_t make_xfer(input kind_t k, input logic [7:0] b,
                                      input logic to);
    xfer_t x;
    x.kind      = k;
    x.tx_byte   = b;
    x.timed_out = to;
    return x;
  endfunction

  // Advance the shadow sequencer by one accepted transaction and queue the
  // transfer it causes, if any.
  task automatic compute_transfer(input cmd_t c);
    xfer_t t;
    bit    produced;
    produced = 1'b0;
    t = '0;
    if (seq_state == SEQ_IDLE) begin
      case (c.op)
        OP_LOAD: begin
          page_copy[c.buffer_index] = c.buffer_byte;
          effective_items++;
        end
        OP_ERASE, OP_PROGRAM: begin
          // Latch the poll budget with the command.
          do_program      = (c.op == OP_PROGRAM);
          cmd_address     = c.flash_address;
          bytes_sent      = '0;
          polls_remaining = poll_budget;
          seq_state       = AWAIT_WREN;
          t = make_xfer(KIND_FRAME, OPC_WREN, 1'b0);
          produced = 1'b1;
          effective_items++;
        end
        default: ;  // transfer done with nothing running
      endcase
    end else if (c.op == OP_DONE) begin
      produced = 1'b1;
      effective_items++;
      case (seq_state)
        AWAIT_WREN: begin
          seq_state = AWAIT_CMD;
          t = make_xfer(KIND_FRAME, do_program ? OPC_PP : OPC_SE, 1'b0);
        end
        AWAIT_CMD: begin
          seq_state = AWAIT_ADDR_HI;
          t = make_xfer(KIND_SEND, cmd_address[23:16], 1'b0);
        end
        AWAIT_ADDR_HI: begin
          seq_state = AWAIT_ADDR_MID;
          t = make_xfer(KIND_SEND, cmd_address[15:8], 1'b0);
        end
        AWAIT_ADDR_MID: begin
          seq_state = AWAIT_ADDR_LO;
          t = make_xfer(KIND_SEND, cmd_address[7:0], 1'b0);
        end
        AWAIT_ADDR_LO, AWAIT_DATA: begin
          if (do_program && bytes_sent < PAGE_BYTES) begin
            t = make_xfer(KIND_SEND, page_copy[bytes_sent[7:0]], 1'b0);
            bytes_sent++;
            seq_state = AWAIT_DATA;
          end else begin
            seq_state = AWAIT_RDSR;
            t = make_xfer(KIND_FRAME, OPC_RDSR, 1'b0);
          end
        end
        AWAIT_RDSR: begin
          seq_state = AWAIT_STATUS;
          t = make_xfer(KIND_SEND, DUMMY_BYTE, 1'b0);
        end
        default: begin
          // Status poll: keep polling while busy and budget remains.
          if (c.rx_byte[0] && polls_remaining != '0) begin
            polls_remaining--;
            t = make_xfer(KIND_SEND, DUMMY_BYTE, 1'b0);
          end else begin
            seq_state = SEQ_IDLE;
            t = make_xfer(KIND_END, 8'h00, c.rx_byte[0]);
          end
        end
      endcase
    end
    if (produced) due_transfers.push_back(t);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cmd_t random_fields(input op_t op);
    cmd_t c;
    c.op            = op;
    c.flash_address = 24'($urandom);
    c.buffer_index  = 8'($urandom);
    c.buffer_byte   = 8'($urandom);
    c.rx_byte       = 8'($urandom);
    return c;
  endfunction

  // Offer one transaction after a random gap and hold it until taken.
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    compute_transfer(c);
  endtask

  task automatic issue_command(input op_t op, input logic [23:0] address);
    cmd_t c;
    c = random_fields(op);
    c.flash_address = address;
    send_cmd(c);
  endtask

  // Feed transfer-done transactions until the command completes. The first
  // busy_polls status reads report busy; noisy mixes in ignored commands.
  task automatic finish_command(input int busy_polls, input bit noisy);
    int   polls_seen;
    cmd_t c;
    polls_seen = 0;
    while (seq_state != SEQ_IDLE) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_cmd(random_fields(op_t'($urandom_range(0, 2))));
      end else begin
        c = random_fields(OP_DONE);
        if (seq_state == AWAIT_STATUS) begin
          c.rx_byte[0] = (polls_seen < busy_polls);
          polls_seen++;
        end
        send_cmd(c);
      end
    end
  endtask

  // Drop valid, wait for every forecast transfer, then let the pipe drain.
  task automatic settle();
    cmd_valid <= 1'b0;
    while (due_transfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_poll_limit(input logic [23:0] value);
    settle();
    cfg_valid      <= 1'b1;
    cfg_poll_limit <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    poll_budget = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t",
             what, got, want, $realtime);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_transfer_done_when_idle();
    cmd_t c;
    c = random_fields(OP_DONE);
    c.rx_byte = 8'h00;
    send_cmd(c);
    c.rx_byte = 8'hFF;
    send_cmd(c);
    send_cmd(random_fields(OP_DONE));
    settle();
  endtask

  // Erase at both ends of the address space under the reset poll budget.
  task automatic test_erase_sequence();
    issue_command(OP_ERASE, 24'h000000);
    finish_command(0, 1'b0);
    issue_command(OP_ERASE, 24'hFFFFFF);
    finish_command(2, 1'b0);
  endtask

  task automatic test_commands_ignored_while_busy();
    cmd_t c;
    issue_command(OP_ERASE, 24'($urandom));
    c = random_fields(OP_LOAD);
    c.buffer_index = 8'hFF;
    c.buffer_byte  = 8'h00;
    send_cmd(c);
    send_cmd(random_fields(OP_DONE));
    send_cmd(random_fields(OP_PROGRAM));
    send_cmd(random_fields(OP_ERASE));
    finish_command(1, 1'b1);
  endtask

  // Fill every buffer entry so any later program reads loaded data only.
  task automatic test_page_load();
    cmd_t c;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      c = random_fields(OP_LOAD);
      c.buffer_index = 8'(i);
      if (i == 0) c.buffer_byte = 8'h00;
      if (i == BUF_DEPTH - 1) c.buffer_byte = 8'hFF;
      send_cmd(c);
    end
  endtask

  task automatic test_page_program();
    issue_command(OP_PROGRAM, 24'($urandom));
    finish_command(3, 1'b0);
  endtask

  // Zero budget gives one poll, a small one runs out, the largest never does.
  task automatic test_poll_budget();
    set_poll_limit(24'd0);
    issue_command(OP_ERASE, 24'($urandom));
    finish_command(5, 1'b0);
    set_poll_limit(24'd3);
    issue_command(OP_ERASE, 24'($urandom));
    finish_command(10, 1'b0);
    set_poll_limit(24'hFFFFFF);
    issue_command(OP_ERASE, 24'($urandom));
    finish_command(6, 1'b0);
  endtask

  // Hold the output for a long stretch while items keep coming, so the queue
  // fills and the input stalls; then pause until everything has drained.
  task automatic test_input_backpressure();
    settle();
    sender_quiet = 1'b1;
    hold_request = LONG_HOLD;
    issue_command(OP_ERASE, 24'($urandom));
    finish_command(12, 1'b0);
    sender_quiet = 1'b0;
    settle();
  endtask

  function automatic logic [23:0] pick_poll_limit();
    case ($urandom_range(0, 4))
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 6));
      2:       return 24'hFFFFFF;
      3:       return 24'($urandom);
      default: return POLL_LIMIT_RESET;
    endcase
  endfunction

  task automatic test_random_traffic();
    cmd_t        c;
    logic [23:0] address;
    while (effective_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 5) == 0) set_poll_limit(pick_poll_limit());
      sender_quiet   = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          send_cmd(random_fields(OP_DONE));
        end else begin
          send_cmd(random_fields(OP_LOAD));
        end
      end
      case ($urandom_range(0, 9))
        0:       address = 24'h000000;
        1:       address = 24'hFFFFFF;
        default: address = 24'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        issue_command(OP_PROGRAM, address);
      end else begin
        issue_command(OP_ERASE, address);
      end
      finish_command($urandom_range(0, 7), 1'b1);
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cmd_valid      <= 1'b0;
    cmd            <= '0;
    cfg_valid      <= 1'b0;
    cfg_poll_limit <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_transfer_done_when_idle();
    test_erase_sequence();
    test_commands_ignored_while_busy();
    test_page_load();
    test_page_program();
    test_poll_budget();
    test_input_backpressure();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall before each transaction, plus the long hold.
  // --------------------------------------------------------------------------
  initial begin : xfer_receiver
    int gap;
    xfer_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = receiver_quiet ? 0 : $urandom_range(0, 17);
      end
      if (gap != 0) begin
        xfer_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      xfer_stall <= 1'b0;
      do @(posedge clk); while (!(xfer_valid && !xfer_stall));
    end
  end

  // Compare every accepted transfer with the oldest forecast one.
  always @(posedge clk) begin : transfer_checker
    xfer_t want;
    if (!rst && xfer_valid && !xfer_stall) begin
      if (due_transfers.size() == 0) begin
        flag_mismatch("transfer with none pending", 32'(xfer), 32'd0);
      end else begin
        want = due_transfers.pop_front();
        if (xfer.kind !== want.kind)
          flag_mismatch("kind", 32'(xfer.kind), 32'(want.kind));
        if (xfer.tx_byte !== want.tx_byte)
          flag_mismatch("tx_byte", 32'(xfer.tx_byte), 32'(want.tx_byte));
        if (xfer.timed_out !== want.timed_out)
          flag_mismatch("timed_out", 32'(xfer.timed_out), 32'(want.timed_out));
      end
    end
  end

  // End the run when no transaction moves on any channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (xfer_valid && !xfer_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

[files.f]
design/ssq_pkg.sv
design/ssq_front.sv
design/ssq_fifo.sv
design/ssq_back.sv
design/spi_flash_erase_program_sequencer.sv
tb/spi_flash_erase_program_sequencer_test.sv
